// ===== rtl/tss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer slot scheduler package
// Transaction types, request and result codes, and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package tss_pkg;

	// request kinds
	localparam logic [1:0] KIND_SCHEDULE = 2'd0;
	localparam logic [1:0] KIND_CANCEL   = 2'd1;
	localparam logic [1:0] KIND_ADVANCE  = 2'd2;
	localparam logic [1:0] KIND_UNUSED   = 2'd3;

	// result kinds
	localparam logic [2:0] RES_SCHEDULED  = 3'd0;
	localparam logic [2:0] RES_FULL       = 3'd1;
	localparam logic [2:0] RES_CANCELLED  = 3'd2;
	localparam logic [2:0] RES_NOT_ACTIVE = 3'd3;
	localparam logic [2:0] RES_FIRED      = 3'd4;
	localparam logic [2:0] RES_DONE       = 3'd5;

	localparam logic [9:0] MS_TO_US = 10'd1000;
	// 31-bit milliseconds times a 10-bit constant
	localparam int PROD_W = 41;

	typedef struct packed {
		logic [1:0]  kind;
		logic [30:0] timeout_ms;
		logic [30:0] interval_ms;
		logic [31:0] elapsed_us;
		logic [3:0]  slot_id;
	} req_t;

	typedef struct packed {
		logic [2:0] result_kind;
		logic [3:0] slot;
		logic       last;
	} rsp_t;

	typedef struct packed {
		logic accept;
		logic advance;
		logic sched_step;
		logic cancel;
		logic walk_issue;
		logic emit_done;
	} cmd_t;

	typedef struct packed {
		logic sched_end;
		logic cnt_last;
	} status_t;

endpackage

// ===== rtl/tss_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer slot scheduler controller
// Sequences schedule scans, cancels and advance walks over the slot table.
// ----------------------------------------------------------------------------
module tss_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       kind,
	input  tss_pkg::status_t status,
	output tss_pkg::cmd_t    cmd,
	output logic             busy
);
	import tss_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCHED,
		S_CANCEL,
		S_WALK,
		S_DRAIN1,
		S_DRAIN2,
		S_DONE
	} state_t;

	state_t state_q;
	logic   busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (kind)
							KIND_SCHEDULE: begin
								state_q <= S_SCHED;
								busy_q  <= 1'b1;
							end
							KIND_CANCEL: begin
								state_q <= S_CANCEL;
								busy_q  <= 1'b1;
							end
							KIND_ADVANCE: begin
								state_q <= S_WALK;
								busy_q  <= 1'b1;
							end
							default: ; // drop unused kind
						endcase
					end
				end
				S_SCHED: begin
					if (status.sched_end) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				S_CANCEL: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				S_WALK: begin
					if (status.cnt_last) begin
						state_q <= S_DRAIN1;
					end
				end
				S_DRAIN1: state_q <= S_DRAIN2;
				S_DRAIN2: state_q <= S_DONE;
				S_DONE: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.accept     = (state_q == S_IDLE) && start;
		cmd.advance    = cmd.accept && (kind == KIND_ADVANCE);
		cmd.sched_step = (state_q == S_SCHED);
		cmd.cancel     = (state_q == S_CANCEL);
		cmd.walk_issue = (state_q == S_WALK);
		cmd.emit_done  = (state_q == S_DONE);
	end

	assign busy = busy_q;

endmodule

// ===== rtl/tss_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer slot scheduler datapath
// Microsecond clock, slot memories, active bits, the compare and re-arm
// pipeline of the advance walk, and the result register.
// ----------------------------------------------------------------------------
module tss_dp #(
	parameter int NUM_SLOTS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tss_pkg::req_t    req,
	input  tss_pkg::cmd_t    cmd,
	output tss_pkg::status_t status,
	output logic             rsp_valid,
	output tss_pkg::rsp_t    rsp
);
	import tss_pkg::*;

	localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int IDX_EXT_W = (SLOT_W > 4) ? SLOT_W : 4;

	function automatic logic [3:0] slot4(input logic [SLOT_W-1:0] idx);
		logic [IDX_EXT_W-1:0] ext;
		ext = IDX_EXT_W'(idx);
		return ext[3:0];
	endfunction

	logic [63:0]         now_q;
	logic [PROD_W-1:0]   prod_q;
	logic [30:0]         interval_q;
	logic [3:0]          slot_id_q;
	logic [SLOT_W-1:0]   cnt_q;
	logic [NUM_SLOTS-1:0] active_q;

	logic [63:0] expiry_mem [NUM_SLOTS];
	logic [30:0] repeat_mem [NUM_SLOTS];

	logic [63:0]       exp_rd_s1;
	logic [30:0]       rep_rd_s1;
	logic [SLOT_W-1:0] idx_s1;
	logic              vld_s1;

	logic              fire_s2;
	logic              rearm_s2;
	logic [SLOT_W-1:0] idx_s2;
	logic [PROD_W-1:0] prod_s2;

	logic        rsp_valid_q;
	rsp_t        rsp_q;

	logic                 cnt_last;
	logic                 cur_free;
	logic [PROD_W-1:0]    wr_addend;
	logic [63:0]          wr_sum;
	logic                 exp_we;
	logic [SLOT_W-1:0]    exp_wa;
	logic [IDX_EXT_W-1:0] sid_ext;
	logic [SLOT_W-1:0]    sid_idx;
	logic                 sid_in_range;
	logic                 sid_hit;
	logic                 fire_d;
	logic [PROD_W-1:0]    prod_rep;
	logic                 emit;
	rsp_t                 rsp_d;

	assign cnt_last = (cnt_q == SLOT_W'(NUM_SLOTS - 1));
	assign cur_free = !active_q[cnt_q];

	assign status.sched_end = cur_free || cnt_last;
	assign status.cnt_last  = cnt_last;

	// one adder serves both the first arm and the re-arm
	assign wr_addend = cmd.sched_step ? prod_q : prod_s2;
	assign wr_sum    = now_q + 64'(wr_addend);
	assign exp_we    = (cmd.sched_step && cur_free) || (fire_s2 && rearm_s2);
	assign exp_wa    = cmd.sched_step ? cnt_q : idx_s2;

	assign sid_ext      = IDX_EXT_W'(slot_id_q);
	assign sid_idx      = sid_ext[SLOT_W-1:0];
	assign sid_in_range = ({28'b0, slot_id_q} < 32'(NUM_SLOTS));
	assign sid_hit      = sid_in_range ? active_q[sid_idx] : 1'b0;

	assign fire_d   = vld_s1 && active_q[idx_s1] && (now_q >= exp_rd_s1);
	assign prod_rep = PROD_W'(rep_rd_s1) * PROD_W'(MS_TO_US);

	always_comb begin
		emit  = 1'b0;
		rsp_d = '0;
		if (cmd.sched_step) begin
			if (cur_free) begin
				emit              = 1'b1;
				rsp_d.result_kind = RES_SCHEDULED;
				rsp_d.slot        = slot4(cnt_q);
				rsp_d.last        = 1'b1;
			end else if (cnt_last) begin
				emit              = 1'b1;
				rsp_d.result_kind = RES_FULL;
				rsp_d.last        = 1'b1;
			end
		end else if (cmd.cancel) begin
			emit              = 1'b1;
			rsp_d.result_kind = sid_hit ? RES_CANCELLED : RES_NOT_ACTIVE;
			rsp_d.slot        = sid_hit ? slot_id_q : 4'd0;
			rsp_d.last        = 1'b1;
		end else if (fire_s2) begin
			emit              = 1'b1;
			rsp_d.result_kind = RES_FIRED;
			rsp_d.slot        = slot4(idx_s2);
		end else if (cmd.emit_done) begin
			emit              = 1'b1;
			rsp_d.result_kind = RES_DONE;
			rsp_d.last        = 1'b1;
		end
	end

	// slot memories
	always_ff @(posedge clk) begin
		if (exp_we) begin
			expiry_mem[exp_wa] <= wr_sum;
		end
		if (cmd.sched_step && cur_free) begin
			repeat_mem[cnt_q] <= interval_q;
		end
		if (cmd.walk_issue) begin
			exp_rd_s1 <= expiry_mem[cnt_q];
			rep_rd_s1 <= repeat_mem[cnt_q];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			prod_q     <= PROD_W'(req.timeout_ms) * PROD_W'(MS_TO_US);
			interval_q <= req.interval_ms;
			slot_id_q  <= req.slot_id;
		end
		idx_s1   <= cnt_q;
		idx_s2   <= idx_s1;
		prod_s2  <= prod_rep;
		rearm_s2 <= (rep_rd_s1 != 31'd0);
		if (emit) begin
			rsp_q <= rsp_d;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q       <= '0;
			active_q    <= '0;
			cnt_q       <= '0;
			vld_s1      <= 1'b0;
			fire_s2     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			vld_s1      <= cmd.walk_issue;
			fire_s2     <= fire_d;
			rsp_valid_q <= emit;
			if (cmd.advance) begin
				now_q <= now_q + 64'(req.elapsed_us);
			end
			if (cmd.accept) begin
				cnt_q <= '0;
			end else if (cmd.walk_issue || (cmd.sched_step && !status.sched_end)) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.sched_step && cur_free) begin
				active_q[cnt_q] <= 1'b1;
			end
			if (cmd.cancel && sid_hit) begin
				active_q[sid_idx] <= 1'b0;
			end
			// free a one-shot slot once it fires
			if (fire_s2 && !rearm_s2) begin
				active_q[idx_s2] <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/timer_slot_scheduler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer slot scheduler
// Microsecond clock with a table of one-shot and periodic timer slots.
// ----------------------------------------------------------------------------
// A request is taken on a clock edge with start high and busy low. Results
// appear on rsp for one cycle each with rsp_valid high; the receiver must
// take them as they come, it cannot stall the block. The final result of a
// request has last set, and busy is already low in that cycle.
// A schedule's free-slot search steps through the active bits one slot per
// cycle. An advance walk reads one slot per cycle from the slot memory
// through a two-stage pipeline, the registered read port and then the
// compare and re-arm stage, and then issues the done result. An unused
// request kind is taken and answered with nothing. No clearing pass runs
// after reset.
module timer_slot_scheduler_top #(
	parameter int NUM_SLOTS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  tss_pkg::req_t req,
	output logic          rsp_valid,
	output tss_pkg::rsp_t rsp
);
	import tss_pkg::*;

	cmd_t    cmd;
	status_t status;

	tss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (req.kind),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	tss_dp #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.status    (status),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

`ifndef SYNTH
	// every used request kind holds the block busy until it answers
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req.kind != KIND_UNUSED) |=> busy)
		else $error("request taken without going busy");

	// the closing result of a transaction releases busy in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.last |-> !busy)
		else $error("busy held after last result");

	// a result without last only appears mid-walk
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |-> busy && (rsp.result_kind == RES_FIRED))
		else $error("stray non-final result");
`endif

endmodule
